// File: hw/rtl/lpg_pkg.sv
// Lorenz point generator package: state encoding, register indexes,
// fixed-point widths, saturation helpers and the sine color table function.
// No dependencies.
package lpg_pkg;

    localparam int PROD_W  = 66;
    localparam int DERIV_W = 39;
    localparam int ACC_W   = 65;
    localparam int STEP_BITS = 24;

    localparam logic [2:0] REG_SIGMA       = 3'd0;
    localparam logic [2:0] REG_BETA        = 3'd1;
    localparam logic [2:0] REG_RHO         = 3'd2;
    localparam logic [2:0] REG_STEP_SIZE   = 3'd3;
    localparam logic [2:0] REG_COLOR_STEP  = 3'd4;
    localparam logic [2:0] REG_POINT_LIMIT = 3'd5;

    localparam logic signed [23:0] SIGMA_RESET = 24'sd655360;
    localparam logic signed [23:0] BETA_RESET  = 24'sd174758;
    localparam logic signed [23:0] RHO_RESET   = 24'sd1835008;
    localparam logic [24:0] STEP_RESET         = 25'd16777;
    localparam logic [31:0] COLOR_STEP_RESET   = 32'd6835652;
    localparam logic [15:0] LIMIT_RESET        = 16'd50000;

    // phase offsets in 2^-32 turn
    localparam logic [31:0] OFFSET_2RAD = 32'd1367130551;
    localparam logic [31:0] OFFSET_4RAD = 32'd2734261102;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    localparam logic signed [66:0] DERIV_MAX = 67'sd137438953472;
    localparam logic signed [66:0] DERIV_MIN = -67'sd137438953472;
    localparam logic signed [65:0] S32_MAX   = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN   = -66'sd2147483648;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_M_SIG,
        ST_M_XRZ,
        ST_M_XY,
        ST_M_BZ,
        ST_M_XLO,
        ST_M_XHI,
        ST_M_YLO,
        ST_M_YHI,
        ST_M_ZLO,
        ST_M_ZHI,
        ST_UPD_Z,
        ST_FINISH
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7fff_ffff;
        else if (v < S32_MIN)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [DERIV_W-1:0] sat_deriv(input logic signed [66:0] v);
        logic signed [DERIV_W-1:0] r;
        if (v > DERIV_MAX)
            r = DERIV_MAX[DERIV_W-1:0];
        else if (v < DERIV_MIN)
            r = DERIV_MIN[DERIV_W-1:0];
        else
            r = v[DERIV_W-1:0];
        return r;
    endfunction

    // 128 + round(127*sin) of p * 2^-32 turn, Q30 Taylor series; elaboration only
    function automatic logic [7:0] sine_entry(input logic [31:0] p);
        logic              neg;
        logic [31:0]       q;
        logic [63:0]       t;
        logic [63:0]       t2;
        logic [63:0]       term;
        logic signed [63:0] sum;
        logic signed [63:0] s;
        logic signed [63:0] r;
        neg = 1'b0;
        q = p;
        if (q >= 32'h8000_0000)
        begin
            neg = 1'b1;
            q = q - 32'h8000_0000;
        end
        if (q > 32'h4000_0000)
            q = 32'h8000_0000 - q;
        t = (64'(q) * TWO_PI_Q30) >> 32;
        t2 = (t * t) >> 30;
        term = t;
        sum = signed'(t);
        for (int n = 1; n <= 6; n++)
        begin
            term = (term * t2) >> 30;
            case (n)
                1: term = term / 6;
                2: term = term / 20;
                3: term = term / 42;
                4: term = term / 72;
                5: term = term / 110;
                default: term = term / 156;
            endcase
            if (n % 2 == 1)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        s = neg ? -sum : sum;
        r = (64'sd127 * s + 64'sd536870912) >>> 30;
        return 8'(64'sd128 + r);
    endfunction

endpackage

// File: hw/rtl/lorenz_point_generator.sv
// A new input word is accepted only in idle, after the previous result is loaded;
// ten products run through one shared 33x33 multiplier under the sequencer,
// between prep and output load; once done, it skips from the x*y product to the output load.
// Reset (rst_n, async low): registers to defaults, point (1,1,1), count and
// phase zero, no output pending. The color table is constant, no clearing pass.
module lorenz_point_generator
    import lpg_pkg::*;
#(
    parameter int FRACTION_BITS    = 16,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [0] restart, [7:1] zero
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // pos_x, pos_y, pos_z, red, green, blue, point_index
    output logic         m_axis_tuser    // done_res
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;

    state_t state_reg, state_next;

    logic signed [23:0] sigma_reg, beta_reg, rho_reg;
    logic [24:0]        step_reg;
    logic [31:0]        color_step_reg;
    logic [15:0]        limit_reg;

    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [15:0]        count_reg;
    logic [31:0]        phase_reg;
    logic               done_reg;
    logic               out_valid_reg;

    logic signed [32:0]        diff_reg;
    logic signed [31:0]        rz_reg;
    logic signed [DERIV_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [PROD_W-1:0]  t_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [7:0]                red_reg, green_reg, blue_reg;

    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic [7:0]         out_red_reg, out_green_reg, out_blue_reg;
    logic [15:0]        out_index_reg;
    logic               out_done_reg;

    logic                     in_accept;
    logic                     load_out;
    logic signed [32:0]       op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_q;
    logic [31:0]              rom_phase;
    logic [7:0]               color_q;
    logic signed [31:0]       coord_new;
    logic signed [ACC_W-1:0]  acc_sum;

    lpg_mul u_mul
    (
        .clk  (clk),
        .a    (op_a),
        .b    (op_b),
        .prod (prod)
    );

    lpg_color_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom
    (
        .clk   (clk),
        .phase (rom_phase),
        .color (color_q)
    );

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign prod_q        = prod >>> FRACTION_BITS;
    assign acc_sum       = acc_reg + (ACC_W'(prod) <<< 16);
    assign coord_new     = sat32(PROD_W'(acc_sum >>> STEP_BITS));

    always_comb
    begin
        state_next = state_reg;
        op_a       = diff_reg;
        op_b       = 33'(sigma_reg);
        rom_phase  = phase_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_M_SIG;
            end
            ST_M_SIG:
            begin
                rom_phase  = phase_reg + OFFSET_2RAD;
                state_next = ST_M_XRZ;
            end
            ST_M_XRZ:
            begin
                op_a       = 33'(x_reg);
                op_b       = 33'(rz_reg);
                rom_phase  = phase_reg + OFFSET_4RAD;
                state_next = ST_M_XY;
            end
            ST_M_XY:
            begin
                op_a       = 33'(x_reg);
                op_b       = 33'(y_reg);
                state_next = done_reg ? ST_FINISH : ST_M_BZ;
            end
            ST_M_BZ:
            begin
                op_a       = 33'(z_reg);
                op_b       = 33'(beta_reg);
                state_next = ST_M_XLO;
            end
            ST_M_XLO:
            begin
                op_a       = signed'({17'd0, dx_reg[15:0]});
                op_b       = signed'({8'd0, step_reg});
                state_next = ST_M_XHI;
            end
            ST_M_XHI:
            begin
                op_a       = 33'(dx_reg >>> 16);
                op_b       = signed'({8'd0, step_reg});
                state_next = ST_M_YLO;
            end
            ST_M_YLO:
            begin
                op_a       = signed'({17'd0, dy_reg[15:0]});
                op_b       = signed'({8'd0, step_reg});
                state_next = ST_M_YHI;
            end
            ST_M_YHI:
            begin
                op_a       = 33'(dy_reg >>> 16);
                op_b       = signed'({8'd0, step_reg});
                state_next = ST_M_ZLO;
            end
            ST_M_ZLO:
            begin
                op_a       = signed'({17'd0, dz_reg[15:0]});
                op_b       = signed'({8'd0, step_reg});
                state_next = ST_M_ZHI;
            end
            ST_M_ZHI:
            begin
                op_a       = 33'(dz_reg >>> 16);
                op_b       = signed'({8'd0, step_reg});
                state_next = ST_UPD_Z;
            end
            ST_UPD_Z:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // config and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg      <= SIGMA_RESET;
            beta_reg       <= BETA_RESET;
            rho_reg        <= RHO_RESET;
            step_reg       <= STEP_RESET;
            color_step_reg <= COLOR_STEP_RESET;
            limit_reg      <= LIMIT_RESET;
            x_reg          <= ONE;
            y_reg          <= ONE;
            z_reg          <= ONE;
            count_reg      <= '0;
            phase_reg      <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SIGMA:       sigma_reg      <= cfg_wdata[23:0];
                    REG_BETA:        beta_reg       <= cfg_wdata[23:0];
                    REG_RHO:         rho_reg        <= cfg_wdata[23:0];
                    REG_STEP_SIZE:   step_reg       <= cfg_wdata[24:0];
                    REG_COLOR_STEP:  color_step_reg <= cfg_wdata;
                    REG_POINT_LIMIT: limit_reg      <= cfg_wdata[15:0];
                    default:         ;
                endcase
            end

            if (in_accept && s_axis_tdata[0])
            begin
                x_reg     <= ONE;
                y_reg     <= ONE;
                z_reg     <= ONE;
                count_reg <= '0;
                phase_reg <= '0;
            end

            if (state_reg == ST_PREP)
                done_reg <= (count_reg >= limit_reg);
            if (state_reg == ST_M_YLO)
                x_reg <= coord_new;
            if (state_reg == ST_M_ZLO)
                y_reg <= coord_new;
            if (state_reg == ST_UPD_Z)
                z_reg <= coord_new;

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (!done_reg)
                begin
                    count_reg <= count_reg + 16'd1;
                    phase_reg <= phase_reg + color_step_reg;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_PREP:
            begin
                diff_reg <= 33'(y_reg) - 33'(x_reg);
                rz_reg   <= sat32(PROD_W'(rho_reg) - PROD_W'(z_reg));
            end
            ST_M_SIG:
            begin
                blue_reg <= color_q;
            end
            ST_M_XRZ:
            begin
                red_reg <= color_q;
                dx_reg  <= sat_deriv(67'(prod_q));
            end
            ST_M_XY:
            begin
                green_reg <= color_q;
                dy_reg    <= sat_deriv(67'(prod_q) - 67'(y_reg));
            end
            ST_M_BZ:
            begin
                t_reg <= prod_q;
            end
            ST_M_XLO:
            begin
                dz_reg <= sat_deriv(67'(t_reg) - 67'(prod_q));
            end
            ST_M_XHI:
            begin
                acc_reg <= (ACC_W'(x_reg) <<< STEP_BITS) + ACC_W'(prod);
            end
            ST_M_YHI:
            begin
                acc_reg <= (ACC_W'(y_reg) <<< STEP_BITS) + ACC_W'(prod);
            end
            ST_M_ZHI:
            begin
                acc_reg <= (ACC_W'(z_reg) <<< STEP_BITS) + ACC_W'(prod);
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_z_reg     <= z_reg;
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
            out_index_reg <= count_reg;
            out_done_reg  <= done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_index_reg, out_blue_reg, out_green_reg, out_red_reg,
                            out_z_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_done_reg;

    a_restart_point: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tdata[0]) |=> (x_reg == ONE && z_reg == ONE && count_reg == '0))
        else $error("restart did not reset point");

    a_hold_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && done_reg) |=> (count_reg == $past(count_reg) &&
                                    phase_reg == $past(phase_reg)))
        else $error("count or phase advanced while done");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !done_reg) |=> (count_reg == $past(count_reg) + 16'd1))
        else $error("count did not advance on new point");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !m_axis_tready) |=>
            (state_reg == ST_FINISH))
        else $error("pending word overwritten");

    a_coords_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !in_accept) |=>
            ($stable(x_reg) && $stable(y_reg) && $stable(z_reg)))
        else $error("point changed while idle");

endmodule

// File: hw/rtl/lpg_mul.sv
// Shared 33x33 signed multiplier with registered product.
// Depends on lpg_pkg.
module lpg_mul
    import lpg_pkg::*;
(
    input  logic                     clk,
    input  logic signed [32:0]       a,
    input  logic signed [32:0]       b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// File: hw/rtl/lpg_color_rom.sv
// Sine color table: phase in 2^-32 turn to 8-bit intensity, registered read.
// Depends on lpg_pkg (sine_entry).
module lpg_color_rom
    import lpg_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic        clk,
    input  logic [31:0] phase,
    output logic [7:0]  color
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [7:0]        rom [DEPTH];
    logic [32+IDX_W:0] scaled;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        color_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_tab
        localparam logic [31:0] P = 32'((64'(k) << 32) / DEPTH);
        assign rom[k] = sine_entry(P);
    end

    assign scaled = (33 + IDX_W)'(phase) * (33 + IDX_W)'(DEPTH);
    assign idx    = scaled[32 +: IDX_W];

    always_ff @(posedge clk)
    begin
        color_reg <= rom[idx];
    end

    assign color = color_reg;

endmodule

// File: dv/lorenz_point_checker.sv
`timescale 1ns / 100ps
// Checker for lorenz_point_generator: tracks register writes, predicts each
// result word from its own Euler model and compares it with the output stream.
// Depends on lpg_pkg for the register indexes.
module lorenz_point_checker
    import lpg_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int TABLE_DEPTH   = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_valid,
    input  logic         s_ready,
    input  logic [7:0]   s_data,     // [0] restart, [7:1] zero
    input  logic         m_valid,
    input  logic         m_ready,
    input  logic [135:0] m_data,     // pos_x, pos_y, pos_z, red, green, blue, point_index
    input  logic         m_user,     // done_res
    output int           fail_count,
    output int           pending,
    output int           checked,
    output int           done_seen
);

    localparam int     STEP_SHIFT   = 24;
    localparam longint DERIV_BOUND  = longint'(1) << 37;
    localparam longint UNIT         = longint'(1) << FRACTION_BITS;
    localparam logic [31:0] HUE_RED_OFFSET   = 32'd1367130551;
    localparam logic [31:0] HUE_GREEN_OFFSET = 32'd2734261102;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] index;
        logic        done;
    } point_word_t;

    logic [7:0]  level_lut [TABLE_DEPTH];
    point_word_t expected_points [$];
    point_word_t want_word;
    point_word_t got_word;

    longint      sigma_r, beta_r, rho_r, step_r;
    logic [31:0] color_step_r;
    logic [15:0] limit_r;
    longint      cur_x, cur_y, cur_z;
    logic [15:0] cur_count;
    logic [31:0] cur_phase;

    // 128 + round(127*sin), sine from a Q30 Taylor series
    function automatic logic [7:0] sine_level(input int k);
        bit [31:0] p;
        bit        neg;
        bit [63:0] t, t2, term;
        longint    acc, s, r;
        p = 32'((64'(k) << 32) / TABLE_DEPTH);
        neg = p[31];
        if (neg)
            p = p - 32'h8000_0000;
        if (p > 32'h4000_0000)
            p = 32'h8000_0000 - p;
        t = (64'(p) * 64'd6746518852) >> 32;
        t2 = (t * t) >> 30;
        term = t;
        acc = longint'(t);
        for (int n = 1; n <= 6; n++)
        begin
            term = (term * t2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        s = neg ? -acc : acc;
        r = (127 * s + (longint'(1) << 29)) >>> 30;
        return 8'(128 + r);
    endfunction

    initial
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
            level_lut[k] = sine_level(k);
    end

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_deriv(input longint v);
        if (v > DERIV_BOUND)
            return DERIV_BOUND;
        if (v < -DERIV_BOUND)
            return -DERIV_BOUND;
        return v;
    endfunction

    function automatic logic [7:0] color_at(input logic [31:0] phase);
        return level_lut[(64'(phase) * TABLE_DEPTH) >> 32];
    endfunction

    // one Euler step on the shadow state unless the count is at the limit, returns the word it should produce
    function automatic point_word_t advance_point(input bit restart_bit);
        point_word_t w;
        longint      dx, dy, dz;
        if (restart_bit)
        begin
            cur_x     = UNIT;
            cur_y     = UNIT;
            cur_z     = UNIT;
            cur_count = '0;
            cur_phase = '0;
        end
        w.index = cur_count;
        w.done  = (cur_count >= limit_r);
        if (!w.done)
        begin
            dx = clamp_deriv((sigma_r * (cur_y - cur_x)) >>> FRACTION_BITS);
            dy = clamp_deriv(((cur_x * clamp_s32(rho_r - cur_z)) >>> FRACTION_BITS) - cur_y);
            dz = clamp_deriv(((cur_x * cur_y) >>> FRACTION_BITS)
                             - ((beta_r * cur_z) >>> FRACTION_BITS));
            cur_x = clamp_s32(cur_x + ((dx * step_r) >>> STEP_SHIFT));
            cur_y = clamp_s32(cur_y + ((dy * step_r) >>> STEP_SHIFT));
            cur_z = clamp_s32(cur_z + ((dz * step_r) >>> STEP_SHIFT));
        end
        w.x     = cur_x[31:0];
        w.y     = cur_y[31:0];
        w.z     = cur_z[31:0];
        w.red   = color_at(cur_phase + HUE_RED_OFFSET);
        w.green = color_at(cur_phase + HUE_GREEN_OFFSET);
        w.blue  = color_at(cur_phase);
        if (!w.done)
        begin
            cur_count = cur_count + 16'd1;
            cur_phase = cur_phase + color_step_r;
        end
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_r      = longint'(SIGMA_RESET);
            beta_r       = longint'(BETA_RESET);
            rho_r        = longint'(RHO_RESET);
            step_r       = longint'(STEP_RESET);
            color_step_r = COLOR_STEP_RESET;
            limit_r      = LIMIT_RESET;
            cur_x        = UNIT;
            cur_y        = UNIT;
            cur_z        = UNIT;
            cur_count    = '0;
            cur_phase    = '0;
            expected_points.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SIGMA:       sigma_r      = longint'(signed'(cfg_wdata[23:0]));
                    REG_BETA:        beta_r       = longint'(signed'(cfg_wdata[23:0]));
                    REG_RHO:         rho_r        = longint'(signed'(cfg_wdata[23:0]));
                    REG_STEP_SIZE:   step_r       = longint'(cfg_wdata[24:0]);
                    REG_COLOR_STEP:  color_step_r = cfg_wdata;
                    REG_POINT_LIMIT: limit_r      = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready)
            begin
                got_word = {m_data[31:0], m_data[63:32], m_data[95:64], m_data[103:96],
                            m_data[111:104], m_data[119:112], m_data[135:120], m_user};
                if (expected_points.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result word with nothing expected, actual %h",
                             $time, got_word);
                end
                else
                begin
                    want_word = expected_points.pop_front();
                    check_field("pos_x", want_word.x, got_word.x);
                    check_field("pos_y", want_word.y, got_word.y);
                    check_field("pos_z", want_word.z, got_word.z);
                    check_field("red", 32'(want_word.red), 32'(got_word.red));
                    check_field("green", 32'(want_word.green), 32'(got_word.green));
                    check_field("blue", 32'(want_word.blue), 32'(got_word.blue));
                    check_field("point_index", 32'(want_word.index), 32'(got_word.index));
                    check_field("done_res", 32'(want_word.done), 32'(got_word.done));
                    checked++;
                    if (want_word.done)
                        done_seen++;
                end
            end
            if (s_valid && s_ready)
                expected_points.push_back(advance_point(s_data[0]));
            pending = expected_points.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the lorenz_point_generator testbench: clock, reset, register writes,
// restart words with random idling on both streams, and the verdict.
// Depends on lpg_pkg, lorenz_point_generator and lorenz_point_checker.
module testbench;
    import lpg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [2:0] SPARE_INDEX_HI = 3'd7;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tuser;

    int fail_count, pending, checked, done_seen;
    int words_sent, settings_used, cycle_count;
    bit no_idle;

    lorenz_point_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lorenz_point_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .m_user     (m_axis_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .done_seen  (done_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("testbench NOT OK");
        $finish;
    end

    // result side: random stall per word
    initial
    begin
        int hold;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 13);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input bit restart_bit);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart_bit};
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_coeff();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 13107200)) - 32'd6553600;
            default: return 32'($urandom_range(0, 1966080));
        endcase
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SIGMA;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        no_idle       = 1'b1;
        words_sent    = 0;
        settings_used = 1;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, back-to-back, restart in the middle
        for (int i = 0; i < 6; i++)
            send_word(i == 3);
        no_idle = 1'b0;

        // run into the limit and hold, then restart out of it
        drain();
        write_reg(REG_POINT_LIMIT, 32'd4);
        for (int i = 0; i < 6; i++)
            send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);

        // limit lowered below the count
        drain();
        write_reg(REG_POINT_LIMIT, 32'd1000);
        send_word(1'b0);
        send_word(1'b0);
        drain();
        write_reg(REG_POINT_LIMIT, 32'd2);
        send_word(1'b0);

        // zero limit right after restart
        drain();
        write_reg(REG_POINT_LIMIT, 32'd0);
        send_word(1'b1);

        // extremes, step size above 1.0 drives saturation
        drain();
        write_reg(REG_SIGMA, 32'h007f_ffff);
        write_reg(REG_BETA, 32'h0080_0000);
        write_reg(REG_RHO, 32'h007f_ffff);
        write_reg(REG_STEP_SIZE, 32'h01ff_ffff);
        write_reg(REG_COLOR_STEP, 32'h7fff_ffff);
        write_reg(REG_POINT_LIMIT, 32'h0000_ffff);
        settings_used++;
        for (int i = 0; i < 4; i++)
            send_word(i == 0);
        drain();
        write_reg(REG_SIGMA, 32'h0080_0000);
        write_reg(REG_BETA, 32'h007f_ffff);
        write_reg(REG_RHO, 32'h0080_0000);
        write_reg(REG_STEP_SIZE, 32'h0000_0000);
        write_reg(REG_COLOR_STEP, 32'h8000_0000);
        write_reg(SPARE_INDEX_LO, $urandom);
        write_reg(SPARE_INDEX_HI, $urandom);
        settings_used++;
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);

        // random settings per phase, restarts now and then
        for (int phase = 0; phase < 12; phase++)
        begin
            drain();
            write_reg(REG_SIGMA, pick_coeff());
            write_reg(REG_BETA, pick_coeff());
            write_reg(REG_RHO, pick_coeff());
            case ($urandom_range(0, 3))
                0: write_reg(REG_STEP_SIZE, $urandom);
                1: write_reg(REG_STEP_SIZE, 32'($urandom_range(0, 33554431)));
                default: write_reg(REG_STEP_SIZE, 32'($urandom_range(0, 65536)));
            endcase
            write_reg(REG_COLOR_STEP, $urandom);
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_POINT_LIMIT, $urandom);
            else
                write_reg(REG_POINT_LIMIT, 32'($urandom_range(0, 300)));
            settings_used++;
            no_idle = (phase % 4 == 3);
            for (int i = 0; i < 125; i++)
            begin
                if (phase == 5 && i == 60)
                    drain();
                send_word($urandom_range(0, 99) < 4);
            end
        end
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);
        $display("sent %0d restart/advance words over %0d register settings", words_sent,
                 settings_used);
        $display("checked %0d points, %0d of them held at the limit", checked, done_seen);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/lpg_pkg.sv
hw/rtl/lpg_mul.sv
hw/rtl/lpg_color_rom.sv
hw/rtl/lorenz_point_generator.sv
dv/lorenz_point_checker.sv
dv/testbench.sv
